### rtl/core/kth_largest_select_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for kth_largest_select_top
// Shared concurrent assertion forms clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KTH_LARGEST_SELECT_TOP_MACROS_SVH
`define KTH_LARGEST_SELECT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/kls_pkg.sv
// ----------------------------------------------------------------------------
// kls_pkg
// Sizes and shared types of the k-th largest selection block.
// ----------------------------------------------------------------------------
package kls_pkg;

  localparam int DEPTH  = 256;
  localparam int WIDTH  = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int RANK_W = 9;

  localparam logic [1:0] ADDR_RANK = 2'd0;

  typedef struct packed {
    logic ins_en;
    logic shift_en;
  } kls_ctl_t;

endpackage

### rtl/core/kth_largest_select_top.sv
// ----------------------------------------------------------------------------
// kth_largest_select_top
// Keeps a set of signed values sorted in a chain of cells and returns the
// value at the configured rank when the last beat of the set arrives.
// ----------------------------------------------------------------------------
// A beat without is_last leaves busy low, so such beats can follow each other in
// every cycle. A beat with is_last holds busy high while the chain shifts the
// wanted entry toward its head, one position per cycle, before the result
// strobe; on a rank error the strobe comes without any shift. busy drops in the
// cycle of the strobe, so a new set may start there. The result is shown for
// one cycle only.
// ----------------------------------------------------------------------------
`include "kth_largest_select_top_macros.svh"

module kth_largest_select_top
  import kls_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_value,
  input  logic               in_is_last,
  output logic               out_valid,
  output logic signed [31:0] out_selected,
  output logic               out_rank_error,
  output logic               out_overflowed,
  output logic [8:0]         out_element_count
);

  typedef enum logic {
    ST_IDLE,
    ST_SELECT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic [RANK_W-1:0]   rank_r;
  logic [RANK_W-1:0]   shift_cnt_r, shift_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic signed [31:0]  out_sel_r, out_sel_nxt;
  logic                out_err_r, out_err_nxt;
  logic                out_ovf_r, out_ovf_nxt;
  logic [8:0]          out_cnt_r, out_cnt_nxt;

  kls_ctl_t                ctl;
  logic                    accept;
  logic                    rank_err;
  logic signed [WIDTH-1:0] key;
  logic                    cell_valid [DEPTH];
  logic                    cell_ins   [DEPTH];
  logic signed [WIDTH-1:0] cell_val   [DEPTH];

  assign pready = 1'b1;
  assign prdata = 32'(rank_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= RANK_W'(1);
    end else if (psel && penable && pwrite && pready && paddr == ADDR_RANK) begin
      rank_r <= pwdata[RANK_W-1:0];
    end
  end

  assign busy   = (state_r == ST_SELECT);
  assign accept = start && !busy;
  assign key    = WIDTH'(in_value);
  assign rank_err = (rank_r == '0) || (32'(rank_r) > 32'(count_r));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    p_ins;
    logic signed [WIDTH-1:0] p_val;
    logic signed [WIDTH-1:0] n_val;

    assign cell_valid[i] = CNT_W'(i) < count_r;

    if (i == 0) begin : g_head
      assign p_ins = 1'b0;
      assign p_val = key;
    end else begin : g_body
      assign p_ins = cell_ins[i-1];
      assign p_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign n_val = cell_val[i];
    end else begin : g_inner
      assign n_val = cell_val[i+1];
    end

    kls_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cell_valid (cell_valid[i]),
      .key        (key),
      .prev_ins   (p_ins),
      .prev_val   (p_val),
      .next_val   (n_val),
      .ins        (cell_ins[i]),
      .val        (cell_val[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    shift_cnt_nxt = shift_cnt_r;
    out_valid_nxt = 1'b0;
    out_sel_nxt   = out_sel_r;
    out_err_nxt   = out_err_r;
    out_ovf_nxt   = out_ovf_r;
    out_cnt_nxt   = out_cnt_r;
    ctl           = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (32'(count_r) < DEPTH) begin
            ctl.ins_en = 1'b1;
            count_nxt  = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_is_last) begin
            state_nxt     = ST_SELECT;
            shift_cnt_nxt = rank_r - RANK_W'(1);
          end
        end
      end
      ST_SELECT: begin
        if (rank_err || shift_cnt_r == '0) begin
          out_valid_nxt = 1'b1;
          out_sel_nxt   = rank_err ? 32'sd0 : 32'(cell_val[0]);
          out_err_nxt   = rank_err;
          out_ovf_nxt   = ovf_r;
          out_cnt_nxt   = 9'(count_r);
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          ctl.shift_en  = 1'b1;
          shift_cnt_nxt = shift_cnt_r - RANK_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    shift_cnt_r <= shift_cnt_nxt;
    out_sel_r   <= out_sel_nxt;
    out_err_r   <= out_err_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_selected      = out_sel_r;
  assign out_rank_error    = out_err_r;
  assign out_overflowed    = out_ovf_r;
  assign out_element_count = out_cnt_r;

  `KLS_ASSERT_IMP(a_strobe_idle, out_valid, !busy, "Result beat while still selecting.")
  `KLS_ASSERT_IMP(a_set_cleared, out_valid, count_r == '0 && !ovf_r, "Set not emptied.")
  `KLS_ASSERT_IMP(a_err_zero, out_valid && out_rank_error, out_selected == 32'sd0,
                  "Error beat carries a value.")
  `KLS_ASSERT_IMP(a_count_range, 1'b1, 32'(count_r) <= DEPTH, "Element count beyond store depth.")
  `KLS_ASSERT_NXT(a_last_busy, accept && in_is_last, busy, "Last beat did not start selection.")

endmodule

### rtl/core/kls_cell.sv
// ----------------------------------------------------------------------------
// kls_cell
// One element of the sorted chain: takes a new value, the value of the
// previous cell, or the value of the next cell.
// ----------------------------------------------------------------------------
module kls_cell
  import kls_pkg::*;
(
  input  logic                    clk,
  input  kls_ctl_t                ctl,
  input  logic                    cell_valid,
  input  logic signed [WIDTH-1:0] key,
  input  logic                    prev_ins,
  input  logic signed [WIDTH-1:0] prev_val,
  input  logic signed [WIDTH-1:0] next_val,
  output logic                    ins,
  output logic signed [WIDTH-1:0] val
);

  logic signed [WIDTH-1:0] val_r;
  logic signed [WIDTH-1:0] val_nxt;

  assign ins = !cell_valid || (key > val_r);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins_en && ins) begin
      val_nxt = prev_ins ? prev_val : key;
    end else if (ctl.shift_en) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### sim/kls_checker.sv
// ----------------------------------------------------------------------------
// kls_checker
// Watches the configuration port and both beat channels of the k-th largest
// selection block. It keeps its own sorted copy of the open set and the rank,
// and compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kls_checker
  import kls_pkg::*;
#(
  parameter logic [1:0] RANK_ADDR = 2'd0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [1:0]              paddr,
  input  logic [31:0]             pwdata,
  input  logic                    pready,
  input  logic                    start,
  input  logic                    busy,
  input  logic signed [WIDTH-1:0] in_value,
  input  logic                    in_is_last,
  input  logic                    out_valid,
  input  logic signed [WIDTH-1:0] out_selected,
  input  logic                    out_rank_error,
  input  logic                    out_overflowed,
  input  logic [8:0]              out_element_count,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic signed [WIDTH-1:0] selected;
    logic                    rank_error;
    logic                    overflowed;
    logic [8:0]              element_count;
  } sel_result_t;

  logic signed [WIDTH-1:0] set_values[$];
  sel_result_t             selections[$];
  logic                    set_dropped;
  logic [RANK_W-1:0]       cur_rank;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic void insert_sorted(input logic signed [WIDTH-1:0] v);
    int pos;
    pos = 0;
    while (pos < set_values.size() && set_values[pos] >= v) pos++;
    set_values.insert(pos, v);
  endfunction

  function automatic sel_result_t close_set();
    sel_result_t r;
    r.element_count = 9'(set_values.size());
    r.overflowed    = set_dropped;
    r.rank_error    = (cur_rank == 0) || (cur_rank > set_values.size());
    r.selected      = r.rank_error ? '0 : set_values[cur_rank - 1];
    return r;
  endfunction

  always @(posedge clk) begin
    sel_result_t want;
    if (!rst_n) begin
      set_values.delete();
      selections.delete();
      set_dropped = 1'b0;
      cur_rank    = RANK_W'(1);
    end else begin
      if (out_valid) begin
        if (selections.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = selections.pop_front();
          if (out_selected !== want.selected)
            report_mismatch($sformatf("selected %0d, expected %0d",
                                      out_selected, want.selected));
          if (out_rank_error !== want.rank_error)
            report_mismatch($sformatf("rank_error %b, expected %b",
                                      out_rank_error, want.rank_error));
          if (out_overflowed !== want.overflowed)
            report_mismatch($sformatf("overflowed %b, expected %b",
                                      out_overflowed, want.overflowed));
          if (out_element_count !== want.element_count)
            report_mismatch($sformatf("element_count %0d, expected %0d",
                                      out_element_count, want.element_count));
        end
      end
      if (psel && penable && pwrite && pready && paddr == RANK_ADDR) begin
        cur_rank = pwdata[RANK_W-1:0];
      end
      if (start && !busy) begin
        if (set_values.size() < DEPTH) insert_sorted(in_value);
        else set_dropped = 1'b1;
        if (in_is_last) begin
          selections.push_back(close_set());
          set_values.delete();
          set_dropped = 1'b0;
        end
      end
    end
    pending <= selections.size();
  end

endmodule

### sim/tb_kth_largest_select_top.sv
// ----------------------------------------------------------------------------
// tb_kth_largest_select_top
// Drives sets of signed values into the k-th largest selection block under
// several ranks and idle patterns: a directed opening over the extremes, then
// random sets, including a full set and an overflowing one. A checker module
// predicts and compares every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_kth_largest_select_top;
  import kls_pkg::*;

  localparam logic [1:0] RANK_ADDR   = 2'd0;
  localparam int         ITEM_TARGET = 1350;
  localparam logic signed [WIDTH-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [WIDTH-1:0] VAL_MIN = 32'sh80000000;

  logic                    clk;
  logic                    rst_n;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [1:0]              paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    start;
  logic                    busy;
  logic signed [WIDTH-1:0] in_value;
  logic                    in_is_last;
  logic                    out_valid;
  logic signed [WIDTH-1:0] out_selected;
  logic                    out_rank_error;
  logic                    out_overflowed;
  logic [8:0]              out_element_count;

  int fail_count;
  int pending;
  int idle_pct;
  int items_sent;
  int idle_pcts[4] = '{0, 79, 0, 21};

  kth_largest_select_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .start             (start),
    .busy              (busy),
    .in_value          (in_value),
    .in_is_last        (in_is_last),
    .out_valid         (out_valid),
    .out_selected      (out_selected),
    .out_rank_error    (out_rank_error),
    .out_overflowed    (out_overflowed),
    .out_element_count (out_element_count)
  );

  kls_checker #(.RANK_ADDR(RANK_ADDR)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .start             (start),
    .busy              (busy),
    .in_value          (in_value),
    .in_is_last        (in_is_last),
    .out_valid         (out_valid),
    .out_selected      (out_selected),
    .out_rank_error    (out_rank_error),
    .out_overflowed    (out_overflowed),
    .out_element_count (out_element_count),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_beat(input logic signed [WIDTH-1:0] v, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start      <= 1'b1;
    in_value   <= v;
    in_is_last <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // The register is only touched once every result beat has arrived.
  task automatic config_rank(input logic [RANK_W-1:0] r);
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RANK_ADDR;
    pwdata  <= 32'(r);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic signed [WIDTH-1:0] pick_value(input bit narrow);
    logic signed [WIDTH-1:0] v;
    case ($urandom_range(9))
      0:       v = VAL_MAX;
      1:       v = VAL_MIN;
      2:       v = '0;
      3:       v = -1;
      default: v = narrow ? WIDTH'($urandom_range(6) - 3) : WIDTH'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [RANK_W-1:0] pick_rank();
    logic [RANK_W-1:0] r;
    case ($urandom_range(9))
      0:       r = '0;
      1:       r = RANK_W'(DEPTH);
      2:       r = RANK_W'(DEPTH - 1);
      3:       r = RANK_W'($urandom_range(9, 40));
      default: r = RANK_W'($urandom_range(1, 8));
    endcase
    return r;
  endfunction

  task automatic run_set(input int n);
    bit narrow;
    narrow = ($urandom_range(9) < 3);
    for (int i = 1; i <= n; i++) send_beat(pick_value(narrow), i == n);
  endtask

  initial begin
    int seg;
    rst_n      = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = RANK_ADDR;
    pwdata     = '0;
    start      = 1'b0;
    in_value   = '0;
    in_is_last = 1'b0;
    idle_pct   = 0;
    items_sent = 0;
    seg        = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Rank after reset selects the largest value.
    send_beat(VAL_MAX, 1'b0);
    send_beat(VAL_MIN, 1'b0);
    send_beat('0, 1'b0);
    send_beat(-1, 1'b1);
    // The smallest element, which is also the last beat of the set.
    config_rank(RANK_W'(4));
    send_beat(5, 1'b0);
    send_beat(5, 1'b0);
    send_beat(-1, 1'b0);
    send_beat(VAL_MIN, 1'b1);
    config_rank(RANK_W'(2));
    send_beat(7, 1'b0);
    send_beat(7, 1'b0);
    send_beat(7, 1'b1);
    config_rank('0);
    send_beat(3, 1'b1);
    config_rank(RANK_W'(3));
    send_beat(1, 1'b0);
    send_beat(2, 1'b1);
    config_rank(RANK_W'(1));
    send_beat(-5, 1'b1);
    config_rank(RANK_W'(DEPTH));
    send_beat('0, 1'b1);
    config_rank(RANK_W'(2));
    send_beat(VAL_MIN, 1'b0);
    send_beat(VAL_MAX, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      idle_pct = idle_pcts[seg % 4];
      if (seg == 5) begin
        config_rank(RANK_W'(DEPTH));
        run_set(DEPTH);
      end
      if (seg == 11) begin
        config_rank(RANK_W'($urandom_range(1, DEPTH)));
        run_set(DEPTH + $urandom_range(1, 4));
      end
      config_rank(pick_rank());
      repeat ($urandom_range(3, 8)) begin
        run_set(($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12));
      end
      seg++;
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
